FILE: rtl/utf8_stream_decoder_defines.svh
// Assertion macros for the UTF-8 stream decoder.
// UTF8_ASSERT is gated by reset; UTF8_ASSERT_ALWAYS also checks during reset.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define UTF8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UTF8_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UTF8_ASSERT(lbl, prop, msg)
`define UTF8_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;

  // range the next byte of a pending sequence must meet
  typedef enum logic [2:0] {
    RANGE_CONT = 3'd0,  // 80-BF
    RANGE_E0   = 3'd1,  // A0-BF
    RANGE_ED   = 3'd2,  // 80-9F
    RANGE_F0   = 3'd3,  // 90-BF
    RANGE_F4   = 3'd4   // 80-8F
  } range_sel_t;

  typedef enum logic [1:0] {
    LEAD_ASCII,
    LEAD_OPEN,
    LEAD_REJECT
  } lead_kind_t;

  typedef struct packed {
    lead_kind_t  kind;
    logic [1:0]  owed;
    range_sel_t  sel;
    logic [20:0] partial;
  } lead_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  sequence_length;
    logic        status;
    logic        last_of_run;
  } utf8d_result_t;

  function automatic logic in_range(range_sel_t sel, logic [7:0] b);
    logic ok;
    case (sel)
      RANGE_E0: ok = b inside {[8'hA0:8'hBF]};
      RANGE_ED: ok = b inside {[8'h80:8'h9F]};
      RANGE_F0: ok = b inside {[8'h90:8'hBF]};
      RANGE_F4: ok = b inside {[8'h80:8'h8F]};
      default:  ok = b inside {[8'h80:8'hBF]};
    endcase
    return ok;
  endfunction

  function automatic lead_t decode_lead(logic [7:0] b);
    lead_t l;
    l.kind    = LEAD_REJECT;
    l.owed    = 2'd0;
    l.sel     = RANGE_CONT;
    l.partial = '0;
    if (b inside {[8'h00:8'h7F]}) begin
      l.kind = LEAD_ASCII;
    end else if (b inside {[8'hC2:8'hDF]}) begin
      l.kind    = LEAD_OPEN;
      l.owed    = 2'd1;
      l.partial = {10'b0, b[4:0], 6'b0};
    end else if (b inside {[8'hE0:8'hEF]}) begin
      l.kind    = LEAD_OPEN;
      l.owed    = 2'd2;
      l.partial = {5'b0, b[3:0], 12'b0};
      if (b == 8'hE0) begin
        l.sel = RANGE_E0;
      end else if (b == 8'hED) begin
        l.sel = RANGE_ED;
      end
    end else if (b inside {[8'hF0:8'hF4]}) begin
      l.kind    = LEAD_OPEN;
      l.owed    = 2'd3;
      l.partial = {b[2:0], 18'b0};
      if (b == 8'hF0) begin
        l.sel = RANGE_F0;
      end else if (b == 8'hF4) begin
        l.sel = RANGE_F4;
      end
    end
    return l;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

// channel  dir  tdata                              tuser   tlast
// s_axis   in   [7:0] data_byte                    -       end_of_data
// m_axis   out  [20:0] code_point,                 status  last_of_run
//               [23:21] sequence_length
//
// One byte per cycle while the output keeps up; a byte that gives two results
// (bad continuation byte followed by its replay as a lead byte) holds the input
// while both wait in the two-entry result buffer, which drains one per cycle.
// Decode is one combinational pass from the input to the result buffer.
// rst is synchronous and clears the sequence state and empties the result buffer.
// A stalled output keeps up to two results; input is taken only when the
// buffer is empty or its last waiting item leaves in the same cycle.

module utf8_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_data
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] sequence_length
  output logic             m_axis_tuser,   // status
  output logic             m_axis_tlast    // last_of_run
);
  import utf8d_pkg::*;

  logic [20:0]   partial_value, partial_value_next;
  logic [1:0]    bytes_owed, bytes_owed_next;
  range_sel_t    next_range_select, next_range_select_next;
  logic [1:0]    bytes_taken, bytes_taken_next;

  utf8d_result_t out_slot0, out_slot1;
  logic [1:0]    out_count;

  utf8d_result_t res0, res1;
  logic [1:0]    res_count;

  lead_t         lead;
  utf8d_result_t lead_res;
  logic          lead_has;

  logic          accept, pop;
  logic [1:0]    owed_m1;
  logic [2:0]    taken;
  logic [20:0]   cont_bits, cont_cp;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (out_count == 2'd0) || ((out_count == 2'd1) && m_axis_tready);

  assign m_axis_tvalid = (out_count != 2'd0);
  assign m_axis_tdata  = {out_slot0.sequence_length, out_slot0.code_point};
  assign m_axis_tuser  = out_slot0.status;
  assign m_axis_tlast  = out_slot0.last_of_run;

  assign lead    = decode_lead(s_axis_tdata);
  assign owed_m1 = bytes_owed - 2'd1;
  assign taken   = {1'b0, bytes_taken} + 3'd1;

  always_comb begin
    case (owed_m1)
      2'd0:    cont_bits = {15'b0, s_axis_tdata[5:0]};
      2'd1:    cont_bits = {9'b0, s_axis_tdata[5:0], 6'b0};
      default: cont_bits = {3'b0, s_axis_tdata[5:0], 12'b0};
    endcase
  end

  assign cont_cp = partial_value + cont_bits;

  // result of the byte taken as a lead byte; an open sequence gives none unless it is the last byte of data
  always_comb begin
    lead_res = '0;
    lead_has = 1'b1;
    case (lead.kind)
      LEAD_ASCII: begin
        lead_res.code_point      = {13'b0, s_axis_tdata};
        lead_res.sequence_length = 3'd1;
      end
      LEAD_OPEN: begin
        lead_res.code_point      = REPLACEMENT_CHAR;
        lead_res.sequence_length = 3'd1;
        lead_res.status          = 1'b1;
        lead_has                 = s_axis_tlast;
      end
      default: begin
        lead_res.code_point      = REPLACEMENT_CHAR;
        lead_res.sequence_length = 3'd1;
        lead_res.status          = 1'b1;
      end
    endcase
  end

  always_comb begin
    partial_value_next     = partial_value;
    bytes_owed_next        = bytes_owed;
    next_range_select_next = next_range_select;
    bytes_taken_next       = bytes_taken;
    res0                   = '0;
    res1                   = '0;
    res_count              = 2'd0;

    if (bytes_owed == 2'd0 || !in_range(next_range_select, s_axis_tdata)) begin
      if (bytes_owed != 2'd0) begin
        // bad continuation: close pending sequence, then replay byte as a lead
        res0.code_point      = REPLACEMENT_CHAR;
        res0.sequence_length = {1'b0, bytes_taken};
        res0.status          = 1'b1;
        res_count            = 2'd1;
      end
      partial_value_next     = '0;
      bytes_owed_next        = 2'd0;
      next_range_select_next = RANGE_CONT;
      bytes_taken_next       = 2'd0;
      if (lead.kind == LEAD_OPEN && !s_axis_tlast) begin
        partial_value_next     = lead.partial;
        bytes_owed_next        = lead.owed;
        next_range_select_next = lead.sel;
        bytes_taken_next       = 2'd1;
      end
      if (lead_has) begin
        if (res_count == 2'd0) begin
          res0      = lead_res;
          res_count = 2'd1;
        end else begin
          res1      = lead_res;
          res_count = 2'd2;
        end
      end
    end else if (owed_m1 == 2'd0) begin
      res0.code_point        = cont_cp;
      res0.sequence_length   = taken;
      res_count              = 2'd1;
      partial_value_next     = '0;
      bytes_owed_next        = 2'd0;
      next_range_select_next = RANGE_CONT;
      bytes_taken_next       = 2'd0;
    end else if (s_axis_tlast) begin
      res0.code_point        = REPLACEMENT_CHAR;
      res0.sequence_length   = taken;
      res0.status            = 1'b1;
      res_count              = 2'd1;
      partial_value_next     = '0;
      bytes_owed_next        = 2'd0;
      next_range_select_next = RANGE_CONT;
      bytes_taken_next       = 2'd0;
    end else begin
      partial_value_next     = cont_cp;
      bytes_owed_next        = owed_m1;
      next_range_select_next = RANGE_CONT;
      bytes_taken_next       = taken[1:0];
    end

    if (res_count == 2'd1) begin
      res0.last_of_run = 1'b1;
    end else if (res_count == 2'd2) begin
      res1.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value     <= '0;
      bytes_owed        <= 2'd0;
      next_range_select <= RANGE_CONT;
      bytes_taken       <= 2'd0;
    end else if (accept) begin
      partial_value     <= partial_value_next;
      bytes_owed        <= bytes_owed_next;
      next_range_select <= next_range_select_next;
      bytes_taken       <= bytes_taken_next;
    end
  end

  // ready implies the buffer is empty after this cycle's pop
  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 2'd0;
    end else if (accept) begin
      out_count <= res_count;
    end else if (pop) begin
      out_count <= out_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_slot0 <= res0;
      out_slot1 <= res1;
    end else if (pop) begin
      out_slot0 <= out_slot1;
    end
  end

  `UTF8_ASSERT_ALWAYS(a_reset_empties, rst |=> !m_axis_tvalid, "output valid after reset")
  `UTF8_ASSERT(a_count_max, out_count != 2'd3, "result buffer overfilled")
  `UTF8_ASSERT(a_full_blocks, (out_count == 2'd2) |-> !s_axis_tready, "input taken while full")
  `UTF8_ASSERT(a_first_of_pair, (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser, "pair must open with error")
  `UTF8_ASSERT(a_idle_clean, (bytes_owed == 2'd0) |-> (bytes_taken == 2'd0 && partial_value == 21'd0), "stale sequence state")
  `UTF8_ASSERT(a_ascii_len, (m_axis_tvalid && !m_axis_tuser && m_axis_tdata[23:21] == 3'd1) |-> (m_axis_tdata[20:7] == 14'd0), "one-byte result above 7F")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import utf8d_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eod;
    bit         hold;   // wait for all pending chars before this item goes out
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  utf8_stream_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  stream_item_t   byte_q[$];
  utf8d_result_t  exp_chars[$];
  int             n_sent = 0;
  int             errors = 0;
  int             cycle_cnt = 0;
  int             bytes_in = 0;
  int             chars_out = 0;
  int             bad_out = 0;
  int             quads_out = 0;
  logic           byte_took = 1'b0;
  bit             calm;

  // decoder shadow state
  logic [20:0] acc_cp = '0;
  logic [1:0]  owed = '0;
  range_sel_t  want_range = RANGE_CONT;
  logic [1:0]  taken = '0;
  int          step_n;

  function automatic void clear_seq();
    acc_cp = '0;
    owed = '0;
    want_range = RANGE_CONT;
    taken = '0;
  endfunction

  function automatic void emit_char(logic [20:0] cp, logic [2:0] len, logic bad);
    utf8d_result_t r;
    r.code_point = cp;
    r.sequence_length = len;
    r.status = bad;
    r.last_of_run = 1'b0;
    exp_chars.push_back(r);
    step_n++;
  endfunction

  function automatic void lead_in(logic [7:0] b, logic eod);
    logic [1:0]  n;
    range_sel_t  sel;
    logic [20:0] top;
    n = 2'd0;
    sel = RANGE_CONT;
    top = '0;
    if (b <= 8'h7F) begin
      emit_char({13'b0, b}, 3'd1, 1'b0);
      return;
    end
    if (b >= 8'hC2 && b <= 8'hDF) begin
      n = 2'd1;
      top = {16'b0, b[4:0]};
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      n = 2'd2;
      top = {17'b0, b[3:0]};
      if (b == 8'hE0) sel = RANGE_E0;
      else if (b == 8'hED) sel = RANGE_ED;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      n = 2'd3;
      top = {18'b0, b[2:0]};
      if (b == 8'hF0) sel = RANGE_F0;
      else if (b == 8'hF4) sel = RANGE_F4;
    end
    if (n == 2'd0) begin
      emit_char(REPLACEMENT_CHAR, 3'd1, 1'b1);
      return;
    end
    if (eod) begin
      clear_seq();
      emit_char(REPLACEMENT_CHAR, 3'd1, 1'b1);
      return;
    end
    acc_cp = top << (6 * n);
    owed = n;
    want_range = sel;
    taken = 2'd1;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eod);
    logic        ok;
    logic [1:0]  left;
    logic [2:0]  took;
    logic [20:0] cp;
    utf8d_result_t r;
    step_n = 0;
    if (owed == 2'd0) begin
      lead_in(b, eod);
    end else begin
      case (want_range)
        RANGE_E0: ok = (b >= 8'hA0 && b <= 8'hBF);
        RANGE_ED: ok = (b >= 8'h80 && b <= 8'h9F);
        RANGE_F0: ok = (b >= 8'h90 && b <= 8'hBF);
        RANGE_F4: ok = (b >= 8'h80 && b <= 8'h8F);
        default:  ok = (b >= 8'h80 && b <= 8'hBF);
      endcase
      if (ok) begin
        left = owed - 2'd1;
        took = {1'b0, taken} + 3'd1;
        cp = acc_cp + ({15'b0, b[5:0]} << (6 * left));
        if (left == 2'd0) begin
          clear_seq();
          emit_char(cp, took, 1'b0);
        end else if (eod) begin
          clear_seq();
          emit_char(REPLACEMENT_CHAR, took, 1'b1);
        end else begin
          acc_cp = cp;
          owed = left;
          want_range = RANGE_CONT;
          taken = took[1:0];
        end
      end else begin
        // bad continuation: close the open sequence, then replay as a lead byte
        took = {1'b0, taken};
        clear_seq();
        emit_char(REPLACEMENT_CHAR, took, 1'b1);
        lead_in(b, eod);
      end
    end
    if (step_n > 0) begin
      r = exp_chars.pop_back();
      r.last_of_run = 1'b1;
      exp_chars.push_back(r);
    end
  endfunction

  // stimulus helpers
  function automatic void send(logic [7:0] b, logic eod = 1'b0, bit hold = 1'b0);
    stream_item_t it;
    it.data = b;
    it.eod = eod;
    it.hold = hold;
    byte_q.push_back(it);
    n_sent++;
  endfunction

  function automatic int encode(int unsigned cp, output logic [7:0] seq[4]);
    if (cp < 32'h80) begin
      seq[0] = cp[7:0];
      return 1;
    end
    if (cp < 32'h800) begin
      seq[0] = 8'hC0 | cp[10:6];
      seq[1] = 8'h80 | cp[5:0];
      return 2;
    end
    if (cp < 32'h10000) begin
      seq[0] = 8'hE0 | cp[15:12];
      seq[1] = 8'h80 | cp[11:6];
      seq[2] = 8'h80 | cp[5:0];
      return 3;
    end
    seq[0] = 8'hF0 | cp[20:18];
    seq[1] = 8'h80 | cp[17:12];
    seq[2] = 8'h80 | cp[11:6];
    seq[3] = 8'h80 | cp[5:0];
    return 4;
  endfunction

  function automatic int unsigned pick_cp(int len);
    int unsigned cp;
    case (len)
      1: cp = $urandom_range(0, 32'h7F);
      2: cp = $urandom_range(32'h80, 32'h7FF);
      3: begin
        cp = $urandom_range(32'h800, 32'hFFFF);
        if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp - 32'h800;
      end
      default: cp = $urandom_range(32'h10000, 32'h10FFFF);
    endcase
    return cp;
  endfunction

  // a byte that fails the range required at position pos after lead
  function automatic logic [7:0] bad_follow(logic [7:0] lead, int pos);
    logic [7:0] lo, hi, b;
    lo = 8'h80;
    hi = 8'hBF;
    if (pos == 1) begin
      if (lead == 8'hE0) lo = 8'hA0;
      else if (lead == 8'hED) hi = 8'h9F;
      else if (lead == 8'hF0) lo = 8'h90;
      else if (lead == 8'hF4) hi = 8'h8F;
    end
    do b = 8'($urandom_range(0, 255)); while (b >= lo && b <= hi);
    return b;
  endfunction

  function automatic void build_stimulus();
    logic [7:0] seq[4];
    int         len, keep, pos, r;
    logic       eod;
    bit         paused = 1'b0;
    // directed: extremes, rejects, restricted second bytes, truncation at end
    send(8'h00); send(8'h7F);
    send(8'hC0); send(8'hC1); send(8'hF5); send(8'hFF);
    send(8'hC2); send(8'h80);
    send(8'hDF); send(8'hBF);
    send(8'hE0); send(8'h9F);                 // E0 second byte too low
    send(8'hED); send(8'hA0);                 // surrogate range
    send(8'hF0); send(8'h90); send(8'h80); send(8'h80);
    send(8'hF4); send(8'h8F); send(8'hBF); send(8'hBF);
    send(8'hF4); send(8'h90);
    send(8'hC2); send(8'hE2);                 // replay opens a new sequence
    send(8'h82); send(8'hAC);
    send(8'hE1); send(8'h80, 1'b1);           // cut off by end of data
    send(8'hC3, 1'b1);
    send(8'h41, 1'b1);
    // random part
    while (n_sent < 1480) begin
      r = $urandom_range(0, 99);
      eod = ($urandom_range(0, 29) == 0);
      len = $urandom_range(1, 4);
      if (r < 70) begin
        len = encode(pick_cp(len), seq);
        for (int i = 0; i < len; i++) begin
          send(seq[i], eod && (i == len - 1), !paused && n_sent >= 700 && i == 0);
          if (n_sent > 700 && i == 0) paused = 1'b1;
        end
      end else if (r < 80) begin
        len = encode(pick_cp($urandom_range(2, 4)), seq);
        keep = $urandom_range(1, len - 1);
        eod = 1'($urandom_range(0, 1));
        for (int i = 0; i < keep; i++) send(seq[i], eod && (i == keep - 1));
      end else if (r < 90) begin
        len = encode(pick_cp($urandom_range(2, 4)), seq);
        pos = $urandom_range(1, len - 1);
        seq[pos] = bad_follow(seq[0], pos);
        for (int i = 0; i <= pos; i++) send(seq[i], eod && (i == pos));
      end else begin
        send(8'($urandom_range(0, 255)), eod);
      end
    end
  endfunction

  // driver
  always @(negedge clk) begin
    stream_item_t cur;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
      if (!s_axis_tvalid || byte_took) begin
        if (byte_q.size() > 0 && (calm || $urandom_range(0, 99) >= 11) &&
            !(byte_q[0].hold && exp_chars.size() != 0)) begin
          cur = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur.data;
          s_axis_tlast  <= cur.eod;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic note_error(string msg);
    if (errors < 10) $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // monitor and checker
  always @(posedge clk) begin
    utf8d_result_t want;
    logic          bad;
    cycle_cnt++;
    calm = (cycle_cnt >= 400 && cycle_cnt < 1000);
    byte_took <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      decode_byte(s_axis_tdata, s_axis_tlast);
      bytes_in++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      chars_out++;
      if (m_axis_tuser) bad_out++;
      else if (m_axis_tdata[23:21] == 3'd4) quads_out++;
      if (exp_chars.size() == 0) begin
        note_error($sformatf("unexpected item cp=%h len=%0d st=%b last=%b",
                             m_axis_tdata[20:0], m_axis_tdata[23:21], m_axis_tuser,
                             m_axis_tlast));
      end else begin
        want = exp_chars.pop_front();
        bad = (m_axis_tdata[20:0] !== want.code_point) ||
              (m_axis_tdata[23:21] !== want.sequence_length) ||
              (m_axis_tuser !== want.status) ||
              (m_axis_tlast !== want.last_of_run);
        if (bad)
          note_error($sformatf("exp cp=%h len=%0d st=%b last=%b, got cp=%h len=%0d st=%b last=%b",
                               want.code_point, want.sequence_length, want.status,
                               want.last_of_run, m_axis_tdata[20:0], m_axis_tdata[23:21],
                               m_axis_tuser, m_axis_tlast));
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (byte_q.size() == 0 && !s_axis_tvalid);
    wait (exp_chars.size() == 0);
    repeat (20) @(posedge clk);
    if (exp_chars.size() != 0) note_error("chars still expected at end of run");
    $display("tb_top: %0d bytes decoded into %0d chars, %0d flagged invalid, %0d four-byte",
             bytes_in, chars_out, bad_out, quads_out);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: %0d mismatches", errors);
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top: timeout, %0d bytes still queued", byte_q.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/utf8d_pkg.sv
rtl/utf8_stream_decoder.sv
dv/tb_top.sv
